@@ sv/sbus_frame_stick_decoder_macros.svh @@
// Assertion macros used by the checker file of the frame decoder.
`ifndef SBUS_FRAME_STICK_DECODER_MACROS_SVH
`define SBUS_FRAME_STICK_DECODER_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define SFSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define SFSD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/sfsd_pkg.sv @@
`default_nettype none

package sfsd_pkg;

    localparam int FRAME_LEN   = 25;
    localparam int STORE_DEPTH = 24;
    localparam int POS_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int CH_W        = 11;
    localparam int NUM_CH      = 10;
    localparam int STICK_W     = 12;
    localparam int SW_W        = 2;
    localparam int DZ_W        = 10;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int OUT_DATA_W  = 104;

    localparam logic [BYTE_W-1:0] OFFLINE_MARK = 8'h0C;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SW_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SW_HIGH   = 3'd5;

    localparam logic [SW_W-1:0] SW_UP   = 2'd1;
    localparam logic [SW_W-1:0] SW_DOWN = 2'd2;
    localparam logic [SW_W-1:0] SW_MID  = 2'd3;

    localparam logic [BYTE_W-1:0] HEADER_RST    = 8'h0F;
    localparam logic [BYTE_W-1:0] END_RST       = 8'h00;
    localparam logic [CH_W-1:0]   CENTRE_RST    = 11'd1024;
    localparam logic [DZ_W-1:0]   DEAD_ZONE_RST = 10'd10;
    localparam logic [CH_W-1:0]   SW_LOW_RST    = 11'd700;
    localparam logic [CH_W-1:0]   SW_HIGH_RST   = 11'd1300;

    typedef logic [STORE_DEPTH-1:0][BYTE_W-1:0] t_store;

    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [CH_W-1:0]   centre_offset;
        logic [DZ_W-1:0]   dead_zone;
        logic [CH_W-1:0]   switch_low_limit;
        logic [CH_W-1:0]   switch_high_limit;
    } t_cfg;

    typedef struct packed {
        logic at_last;
        logic frame_done;
    } t_cap_status;

    typedef struct packed {
        logic        [CH_W-1:0]    aux_channel_9;
        logic        [CH_W-1:0]    aux_channel_8;
        logic        [CH_W-1:0]    aux_channel_7;
        logic        [CH_W-1:0]    aux_channel_6;
        logic        [SW_W-1:0]    switch_right;
        logic        [SW_W-1:0]    switch_left;
        logic signed [STICK_W-1:0] stick_left_y;
        logic signed [STICK_W-1:0] stick_left_x;
        logic signed [STICK_W-1:0] stick_right_y;
        logic signed [STICK_W-1:0] stick_right_x;
        logic                      link_online;
    } t_result;

endpackage

`default_nettype wire

@@ sv/sbus_frame_stick_decoder.sv @@
`default_nettype none

// Decodes 25-byte radio-control bus frames arriving one byte per transaction on the slave
// side, with tuser marking the first byte of a frame, and takes one byte every cycle. Bytes
// 0 to 23 go into a register store; when byte 24 arrives the header and end bytes are
// checked, and a good frame is unpacked, centered, dead-zoned (all sticks but left Y) and
// classified by short logic straight into the result register, so its result transaction
// is offered on the master side in the cycle after the last byte is taken. A bad frame
// gives no result. The slave side stalls only on the last byte of a frame while the
// previous result is still waiting to be taken. Configuration writes take effect at the
// next clock edge and must be made while no frame is in progress.
module sbus_frame_stick_decoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sfsd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sfsd_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // rx_byte[7:0]
    input  logic [sfsd_pkg::BYTE_W-1:0]        s_axis_tdata,
    // frame_start[0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // link_online[0], stick_right_x[12:1], stick_right_y[24:13], stick_left_x[36:25],
    // stick_left_y[48:37], switch_left[50:49], switch_right[52:51], aux_channel_6[63:53],
    // aux_channel_7[74:64], aux_channel_8[85:75], aux_channel_9[96:86], zeros above
    output logic [sfsd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import sfsd_pkg::*;

    t_cfg        r_cfg, n_cfg;
    t_result     r_result, decoded;
    logic        r_valid, n_valid;
    t_store      store;
    t_cap_status status;
    logic        in_accept;

    assign s_axis_tready = !(r_valid && !m_axis_tready && status.at_last);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    sfsd_capture u_capture (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_byte        (s_axis_tdata),
        .i_start       (s_axis_tuser),
        .i_header_byte (r_cfg.header_byte),
        .i_end_byte    (r_cfg.end_byte),
        .o_store       (store),
        .o_status      (status)
    );

    sfsd_decode u_decode (
        .i_store  (store),
        .i_cfg    (r_cfg),
        .o_result (decoded)
    );

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HEADER:    n_cfg.header_byte       = i_cfg_data[BYTE_W-1:0];
                REG_END:       n_cfg.end_byte          = i_cfg_data[BYTE_W-1:0];
                REG_CENTRE:    n_cfg.centre_offset     = i_cfg_data[CH_W-1:0];
                REG_DEAD_ZONE: n_cfg.dead_zone         = i_cfg_data[DZ_W-1:0];
                REG_SW_LOW:    n_cfg.switch_low_limit  = i_cfg_data[CH_W-1:0];
                REG_SW_HIGH:   n_cfg.switch_high_limit = i_cfg_data[CH_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        n_valid = r_valid;
        priority if (status.frame_done) begin
            n_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_byte       <= HEADER_RST;
            r_cfg.end_byte          <= END_RST;
            r_cfg.centre_offset     <= CENTRE_RST;
            r_cfg.dead_zone         <= DEAD_ZONE_RST;
            r_cfg.switch_low_limit  <= SW_LOW_RST;
            r_cfg.switch_high_limit <= SW_HIGH_RST;
            r_valid                 <= 1'b0;
        end else begin
            r_cfg   <= n_cfg;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (status.frame_done) begin
            r_result <= decoded;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - $bits(t_result))'(0), r_result};

endmodule

`default_nettype wire

@@ sv/sfsd_capture.sv @@
`default_nettype none

module sfsd_capture (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [sfsd_pkg::BYTE_W-1:0]    i_byte,
    input  logic                           i_start,
    input  logic [sfsd_pkg::BYTE_W-1:0]    i_header_byte,
    input  logic [sfsd_pkg::BYTE_W-1:0]    i_end_byte,
    output sfsd_pkg::t_store               o_store,
    output sfsd_pkg::t_cap_status          o_status
);
    import sfsd_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    t_store           r_store, n_store;
    logic [POS_W-1:0] pos_eff;
    logic             frame_done;

    always_comb begin
        pos_eff    = i_start ? '0 : r_pos;
        n_pos      = r_pos;
        n_store    = r_store;
        frame_done = 1'b0;
        if (i_accept) begin
            if (pos_eff >= POS_W'(FRAME_LEN)) begin
                n_pos = POS_W'(FRAME_LEN);
            end else if (pos_eff < POS_W'(STORE_DEPTH)) begin
                n_store[pos_eff] = i_byte;
                n_pos            = pos_eff + POS_W'(1);
            end else begin
                n_pos      = POS_W'(FRAME_LEN);
                frame_done = (r_store[0] == i_header_byte) && (i_byte == i_end_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_W'(FRAME_LEN);
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
    end

    assign o_store             = r_store;
    assign o_status.at_last    = (r_pos == POS_W'(STORE_DEPTH));
    assign o_status.frame_done = frame_done;

endmodule

`default_nettype wire

@@ sv/sfsd_decode.sv @@
`default_nettype none

module sfsd_decode (
    input  sfsd_pkg::t_store  i_store,
    input  sfsd_pkg::t_cfg    i_cfg,
    output sfsd_pkg::t_result o_result
);
    import sfsd_pkg::*;

    logic [STORE_DEPTH*BYTE_W-1:0] flat;
    logic [CH_W-1:0]               ch [NUM_CH];

    function automatic logic signed [STICK_W-1:0] centred(
        input logic [CH_W-1:0] c,
        input logic [CH_W-1:0] off
    );
        return $signed({1'b0, c}) - $signed({1'b0, off});
    endfunction

    function automatic logic signed [STICK_W-1:0] dead(
        input logic signed [STICK_W-1:0] v,
        input logic        [DZ_W-1:0]    dz
    );
        logic signed [STICK_W-1:0] dzs;
        dzs = $signed({2'b00, dz});
        return ((v > -dzs) && (v < dzs)) ? '0 : v;
    endfunction

    function automatic logic [SW_W-1:0] sw_class(
        input logic [CH_W-1:0] c,
        input logic [CH_W-1:0] lo,
        input logic [CH_W-1:0] hi
    );
        logic [SW_W-1:0] code;
        priority if (c < lo) begin
            code = SW_UP;
        end else if (c <= hi) begin
            code = SW_MID;
        end else begin
            code = SW_DOWN;
        end
        return code;
    endfunction

    assign flat = i_store;

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            ch[i] = flat[BYTE_W + CH_W*i +: CH_W];
        end
    end

    always_comb begin
        o_result.link_online   = (i_store[STORE_DEPTH-1] != OFFLINE_MARK);
        o_result.stick_right_x =
            -dead(centred(ch[3], i_cfg.centre_offset), i_cfg.dead_zone);
        o_result.stick_right_y =
            dead(centred(ch[2], i_cfg.centre_offset), i_cfg.dead_zone);
        o_result.stick_left_x  =
            -dead(centred(ch[0], i_cfg.centre_offset), i_cfg.dead_zone);
        o_result.stick_left_y  = -centred(ch[1], i_cfg.centre_offset);
        o_result.switch_left   =
            sw_class(ch[4], i_cfg.switch_low_limit, i_cfg.switch_high_limit);
        o_result.switch_right  =
            sw_class(ch[5], i_cfg.switch_low_limit, i_cfg.switch_high_limit);
        o_result.aux_channel_6 = ch[6];
        o_result.aux_channel_7 = ch[7];
        o_result.aux_channel_8 = ch[8];
        o_result.aux_channel_9 = ch[9];
    end

endmodule

`default_nettype wire

@@ sv/sfsd_checker.sv @@
`default_nettype none

`include "sbus_frame_stick_decoder_macros.svh"

module sfsd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [sfsd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import sfsd_pkg::*;

    t_result result;
    logic    stalled;
    logic    switch_ok;
    logic    stick_ok;

    assign result    = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
    assign stalled   = m_axis_tvalid && !m_axis_tready;
    assign switch_ok = (result.switch_left != '0) && (result.switch_right != '0);
    assign stick_ok  = (result.stick_right_x != 12'sh800) && (result.stick_right_y != 12'sh800)
                    && (result.stick_left_x != 12'sh800) && (result.stick_left_y != 12'sh800);

    `SFSD_ASSERT_RST(a_reset_clears_valid, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    `SFSD_ASSERT(a_valid_hold, stalled |=> m_axis_tvalid, "result dropped while stalled")

    `SFSD_ASSERT(a_data_hold, stalled |=> $stable(m_axis_tdata), "result changed while stalled")

    `SFSD_ASSERT(a_switch_codes, m_axis_tvalid |-> switch_ok, "switch code zero")

    `SFSD_ASSERT(a_stick_range, m_axis_tvalid |-> stick_ok, "stick value out of range")

endmodule

bind sbus_frame_stick_decoder sfsd_checker u_sfsd_checker (.*);

`default_nettype wire
